FILE: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helpers shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int unsigned MaxResults = 6;

    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_STR     = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX     = 3'd3,
        MODE_HELD    = 3'd4,
        MODE_HELD_BS = 3'd5,
        MODE_HEX2    = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_DONE    = 3'd1,
        KIND_BADHEX  = 3'd2,
        KIND_UNTERM  = 3'd3,
        KIND_NOQUOTE = 3'd4
    } t_kind;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] hex_accum;
        logic [1:0]  digit_count;
        logic [9:0]  high_half;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    localparam logic [15:0] HiSurLo  = 16'hD800;
    localparam logic [15:0] HiSurHi  = 16'hDBFF;
    localparam logic [15:0] LoSurLo  = 16'hDC00;
    localparam logic [15:0] LoSurHi  = 16'hDFFF;
    localparam logic [20:0] PlaneOne = 21'h10000;
    localparam logic [20:0] Replace  = 21'h0FFFD;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= "0" && c <= "9") v = 5'(c - 8'h30);
        else if (c >= "a" && c <= "f") v = 5'(c - 8'h57);
        else if (c >= "A" && c <= "F") v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u = '0;
        if (cp <= 21'h7F) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

FILE: hdl/json_string_unescape_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8_unit
// Decodes one quoted JSON string from a byte stream into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Each accepted source byte is decoded in the cycle it arrives and its results
// (zero to six) land in a six-entry result queue that drains one result per
// cycle on the master side while the master is ready. Plain string text streams
// at one byte per clock while the master is ready; a byte that yields several
// results holds off the next byte until they drain through the single-result
// output port. The source side is ready while the queue is empty or giving up
// its last entry. Results appear in the cycle after their source byte.
module json_string_unescape_to_utf8_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] src_byte
    input  logic       i_s_tuser,   // [0] source_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [2:0] o_m_tuser,   // [2:0] out_kind
    output logic       o_m_tlast
);

    jsu_pkg::t_state                               r_state;
    jsu_pkg::t_state                               n_state;
    jsu_pkg::t_result [jsu_pkg::MaxResults-1:0]    r_buf;
    jsu_pkg::t_result [jsu_pkg::MaxResults-1:0]    dec_results;
    logic [2:0]                                    r_cnt;
    logic [2:0]                                    dec_count;
    logic                                          s_fire;
    logic                                          m_fire;

    jsu_decode u_decode (
        .i_state   (r_state),
        .i_byte    (i_s_tdata),
        .i_end     (i_s_tuser),
        .o_state   (n_state),
        .o_results (dec_results),
        .o_count   (dec_count)
    );

    assign o_m_tvalid = (r_cnt != 3'd0);
    assign m_fire     = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_m_tready);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tdata  = r_buf[0].data;
    assign o_m_tuser  = r_buf[0].kind;
    assign o_m_tlast  = r_buf[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: jsu_pkg::MODE_WAIT, hex_accum: '0, digit_count: '0,
                         high_half: '0};
            r_cnt   <= 3'd0;
        end else if (s_fire) begin
            r_state <= n_state;
            r_cnt   <= dec_count;
        end else if (m_fire) begin
            r_cnt <= 3'(r_cnt - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_buf <= dec_results;
        end else if (m_fire) begin
            r_buf <= {jsu_pkg::t_result'(0), r_buf[jsu_pkg::MaxResults-1:1]};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(jsu_pkg::MaxResults))
        else $error("result count out of range");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (r_cnt == 3'd1)))
        else $error("tlast does not match the final queued result");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && !s_fire) |=> (r_cnt == 3'($past(r_cnt) - 3'd1)))
        else $error("queue did not advance by one on a pop");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != jsu_pkg::KIND_DATA) |-> (o_m_tdata == 8'h00))
        else $error("status result carries a nonzero byte");

endmodule

FILE: hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Next state and the full result list for one source byte.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::t_state                         i_state,
    input  logic [7:0]                              i_byte,
    input  logic                                    i_end,
    output jsu_pkg::t_state                         o_state,
    output jsu_pkg::t_result [jsu_pkg::MaxResults-1:0] o_results,
    output logic [2:0]                              o_count
);

    logic            pre_fffd;
    logic            byte_en;
    logic            cp_en;
    jsu_pkg::t_kind  m_kind;
    logic [7:0]      m_byte;
    logic [20:0]     cp;
    jsu_pkg::t_mode  eff_mode;
    logic [4:0]      digit;
    logic [15:0]     acc_new;
    logic            fourth;
    jsu_pkg::t_utf8  pre_u;
    jsu_pkg::t_utf8  main_u;
    logic [2:0]      off;
    logic [2:0]      j;
    logic [2:0]      total;

    always_comb begin
        o_state  = i_state;
        pre_fffd = 1'b0;
        byte_en  = 1'b0;
        cp_en    = 1'b0;
        m_kind   = jsu_pkg::KIND_DATA;
        m_byte   = 8'h00;
        cp       = '0;
        digit    = jsu_pkg::hex_value(i_byte);
        acc_new  = {i_state.hex_accum[11:0], digit[3:0]};
        fourth   = (i_state.digit_count == 2'd3);
        eff_mode = i_state.mode;

        if (i_state.mode == jsu_pkg::MODE_HELD && i_byte != "\\") begin
            pre_fffd = 1'b1;
            eff_mode = jsu_pkg::MODE_STR;
        end
        if (i_state.mode == jsu_pkg::MODE_HELD_BS && i_byte != "u") begin
            pre_fffd = 1'b1;
            eff_mode = jsu_pkg::MODE_ESC;
        end

        if (i_end) begin
            byte_en = 1'b1;
            m_kind  = (i_state.mode inside {jsu_pkg::MODE_STR, jsu_pkg::MODE_ESC,
                       jsu_pkg::MODE_HEX, jsu_pkg::MODE_HELD, jsu_pkg::MODE_HELD_BS,
                       jsu_pkg::MODE_HEX2}) ? jsu_pkg::KIND_UNTERM : jsu_pkg::KIND_NOQUOTE;
            pre_fffd = 1'b0;
            o_state  = '0;
        end else begin
            case (eff_mode)
                jsu_pkg::MODE_STR: begin
                    if (i_byte == "\"") begin
                        byte_en = 1'b1;
                        m_kind  = jsu_pkg::KIND_DONE;
                        o_state = '0;
                    end else if (i_byte == "\\") begin
                        o_state.mode = jsu_pkg::MODE_ESC;
                    end else begin
                        byte_en      = 1'b1;
                        m_byte       = i_byte;
                        o_state.mode = jsu_pkg::MODE_STR;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    o_state.mode = jsu_pkg::MODE_STR;
                    byte_en      = 1'b1;
                    case (i_byte)
                        "b":     m_byte = 8'h08;
                        "f":     m_byte = 8'h0C;
                        "n":     m_byte = 8'h0A;
                        "r":     m_byte = 8'h0D;
                        "t":     m_byte = 8'h09;
                        "u": begin
                            byte_en             = 1'b0;
                            o_state.mode        = jsu_pkg::MODE_HEX;
                            o_state.hex_accum   = '0;
                            o_state.digit_count = '0;
                        end
                        default: m_byte = i_byte;
                    endcase
                end
                jsu_pkg::MODE_HELD: begin
                    o_state.mode = jsu_pkg::MODE_HELD_BS;
                end
                jsu_pkg::MODE_HELD_BS: begin
                    o_state.mode        = jsu_pkg::MODE_HEX2;
                    o_state.hex_accum   = '0;
                    o_state.digit_count = '0;
                end
                jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX2: begin
                    if (digit[4]) begin
                        byte_en = 1'b1;
                        m_kind  = jsu_pkg::KIND_BADHEX;
                        o_state = '0;
                    end else begin
                        o_state.hex_accum   = acc_new;
                        o_state.digit_count = fourth ? 2'd0 : 2'(i_state.digit_count + 2'd1);
                        if (fourth) begin
                            if (eff_mode == jsu_pkg::MODE_HEX2 && acc_new >= jsu_pkg::LoSurLo
                                && acc_new <= jsu_pkg::LoSurHi) begin
                                cp_en        = 1'b1;
                                cp           = jsu_pkg::PlaneOne
                                               + {1'b0, i_state.high_half, acc_new[9:0]};
                                o_state.mode = jsu_pkg::MODE_STR;
                            end else begin
                                pre_fffd = (eff_mode == jsu_pkg::MODE_HEX2);
                                if (acc_new >= jsu_pkg::HiSurLo && acc_new <= jsu_pkg::HiSurHi)
                                begin
                                    o_state.high_half = acc_new[9:0];
                                    o_state.mode      = jsu_pkg::MODE_HELD;
                                end else begin
                                    cp_en = 1'b1;
                                    if (acc_new >= jsu_pkg::LoSurLo && acc_new <= jsu_pkg::LoSurHi)
                                        cp = jsu_pkg::Replace;
                                    else
                                        cp = {5'd0, acc_new};
                                    o_state.mode = jsu_pkg::MODE_STR;
                                end
                            end
                        end
                    end
                end
                default: begin
                    if (i_byte == "\"") begin
                        o_state.mode = jsu_pkg::MODE_STR;
                    end else if (i_byte inside {8'h20, [8'h09:8'h0D]}) begin
                        o_state.mode = jsu_pkg::MODE_WAIT;
                    end else begin
                        byte_en = 1'b1;
                        m_kind  = jsu_pkg::KIND_NOQUOTE;
                        o_state = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        pre_u  = jsu_pkg::utf8_encode(jsu_pkg::Replace);
        main_u = jsu_pkg::utf8_encode(cp);
        off    = pre_fffd ? 3'd3 : 3'd0;
        total  = 3'(off + (byte_en ? 3'd1 : 3'd0) + (cp_en ? main_u.len : 3'd0));
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            o_results[i] = '0;
            j = 3'(3'(i) - off);
            if (pre_fffd && 3'(i) < 3'd3) begin
                o_results[i].data = pre_u.bytes[i[1:0]];
            end else if (byte_en && j == 3'd0) begin
                o_results[i].kind = m_kind;
                o_results[i].data = m_byte;
            end else if (cp_en && j < main_u.len) begin
                o_results[i].data = main_u.bytes[j[1:0]];
            end
            o_results[i].last = (3'(i + 1) == total);
        end
        o_count = total;
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream checker for the JSON string unescaper.
// ----------------------------------------------------------------------------
// Feeds source bytes on the slave stream, with a short directed opening and
// then randomly built strings. The strings mix raw bytes, simple and unknown
// escapes, \u escapes of every UTF-8 length, surrogate pairs, broken
// surrogates, bad hex digits and early source ends. A scoreboard decodes
// every accepted beat on its own and compares each master-side beat with the
// oldest decoded result. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned Limit     = 300000;
    localparam int unsigned RandItems = 350;
    localparam logic [7:0]  Quote     = 8'h22;
    localparam logic [7:0]  Bslash    = 8'h5C;
    localparam logic [7:0]  CharU     = 8'h75;

    class unescape_scoreboard;
        jsu_pkg::t_mode   mode;
        logic [15:0]      hex_acc;
        logic [1:0]       digits;
        logic [9:0]       hi_half;
        jsu_pkg::t_result step_out[$];
        jsu_pkg::t_result pending_out[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode    = jsu_pkg::MODE_WAIT;
            hex_acc = '0;
            digits  = '0;
            hi_half = '0;
        endfunction

        function int unsigned pending();
            return pending_out.size();
        endfunction

        function void push_out(jsu_pkg::t_kind k, logic [7:0] b);
            jsu_pkg::t_result r;
            if (step_out.size() < jsu_pkg::MaxResults) begin
                r.kind = k;
                r.data = b;
                r.last = 1'b0;
                step_out = {step_out, r};
            end
        endfunction

        function void put_code(logic [20:0] cp);
            if (cp <= 21'h7F) begin
                push_out(jsu_pkg::KIND_DATA, cp[7:0]);
            end else if (cp <= 21'h7FF) begin
                push_out(jsu_pkg::KIND_DATA, 8'hC0 | 8'(cp >> 6));
                push_out(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F));
            end else if (cp <= 21'hFFFF) begin
                push_out(jsu_pkg::KIND_DATA, 8'hE0 | 8'(cp >> 12));
                push_out(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F));
                push_out(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F));
            end else begin
                push_out(jsu_pkg::KIND_DATA, 8'hF0 | 8'(cp >> 18));
                push_out(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 12) & 21'h3F));
                push_out(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F));
                push_out(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F));
            end
        endfunction

        function logic [4:0] nibble(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
            if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
            if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
            return 5'd16;
        endfunction

        function void string_char(logic [7:0] c);
            if (c == Quote) begin
                push_out(jsu_pkg::KIND_DONE, 8'h00);
                restart();
            end else if (c == Bslash) begin
                mode = jsu_pkg::MODE_ESC;
            end else begin
                push_out(jsu_pkg::KIND_DATA, c);
                mode = jsu_pkg::MODE_STR;
            end
        endfunction

        function void escape_char(logic [7:0] c);
            mode = jsu_pkg::MODE_STR;
            case (c)
                8'h62: push_out(jsu_pkg::KIND_DATA, 8'h08);
                8'h66: push_out(jsu_pkg::KIND_DATA, 8'h0C);
                8'h6E: push_out(jsu_pkg::KIND_DATA, 8'h0A);
                8'h72: push_out(jsu_pkg::KIND_DATA, 8'h0D);
                8'h74: push_out(jsu_pkg::KIND_DATA, 8'h09);
                CharU: begin
                    mode    = jsu_pkg::MODE_HEX;
                    hex_acc = '0;
                    digits  = '0;
                end
                default: push_out(jsu_pkg::KIND_DATA, c);
            endcase
        endfunction

        function void lone_code(logic [15:0] cp);
            if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                hi_half = 10'(cp - 16'hD800);
                mode    = jsu_pkg::MODE_HELD;
            end else begin
                if (cp >= 16'hDC00 && cp <= 16'hDFFF) put_code(21'hFFFD);
                else put_code(21'(cp));
                mode = jsu_pkg::MODE_STR;
            end
        endfunction

        function bit take_digit(logic [7:0] c);
            logic [4:0] v;
            v = nibble(c);
            if (v > 5'd15) begin
                push_out(jsu_pkg::KIND_BADHEX, 8'h00);
                restart();
                return 1'b0;
            end
            hex_acc = {hex_acc[11:0], v[3:0]};
            if (digits == 2'd3) begin
                digits = '0;
                return 1'b1;
            end
            digits = digits + 2'd1;
            return 1'b0;
        endfunction

        function void note_source(logic [7:0] c, logic ended);
            logic [15:0] lo;
            step_out.delete();
            if (ended) begin
                push_out(mode != jsu_pkg::MODE_WAIT ? jsu_pkg::KIND_UNTERM
                                                    : jsu_pkg::KIND_NOQUOTE, 8'h00);
                restart();
            end else begin
                case (mode)
                    jsu_pkg::MODE_STR: string_char(c);
                    jsu_pkg::MODE_ESC: escape_char(c);
                    jsu_pkg::MODE_HEX: if (take_digit(c)) lone_code(hex_acc);
                    jsu_pkg::MODE_HELD: begin
                        if (c == Bslash) begin
                            mode = jsu_pkg::MODE_HELD_BS;
                        end else begin
                            put_code(21'hFFFD);
                            string_char(c);
                        end
                    end
                    jsu_pkg::MODE_HELD_BS: begin
                        if (c == CharU) begin
                            mode    = jsu_pkg::MODE_HEX2;
                            hex_acc = '0;
                            digits  = '0;
                        end else begin
                            put_code(21'hFFFD);
                            escape_char(c);
                        end
                    end
                    jsu_pkg::MODE_HEX2: begin
                        if (take_digit(c)) begin
                            lo = hex_acc;
                            if (lo >= 16'hDC00 && lo <= 16'hDFFF) begin
                                put_code(21'h10000 + {hi_half, 10'b0} + 21'(lo - 16'hDC00));
                                mode = jsu_pkg::MODE_STR;
                            end else begin
                                put_code(21'hFFFD);
                                lone_code(lo);
                            end
                        end
                    end
                    default: begin
                        if (c == Quote) begin
                            mode = jsu_pkg::MODE_STR;
                        end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
                            push_out(jsu_pkg::KIND_NOQUOTE, 8'h00);
                            restart();
                        end
                    end
                endcase
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
            pending_out = {pending_out, step_out};
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30) $display("%s", msg);
        endtask

        task check_out(logic [2:0] kind, logic [7:0] data, logic last);
            jsu_pkg::t_result w;
            if (pending_out.size() == 0) begin
                report($sformatf("unexpected beat: kind %0d byte %02h last %0b",
                                 kind, data, last));
            end else begin
                w = pending_out.pop_front();
                if (kind != w.kind || data != w.data || last != w.last)
                    report($sformatf("mismatch: got %0d/%02h/%0b want %0d/%02h/%0b",
                                     kind, data, last, w.kind, w.data, w.last));
            end
        endtask
    endclass

    typedef struct {
        logic [7:0] b;
        logic       e;
    } t_src_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic       i_s_tuser;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;
    logic [2:0] o_m_tuser;
    logic       o_m_tlast;

    unescape_scoreboard sb;
    t_src_beat          src_q[$];
    bit                 calm;
    int unsigned        src_gap_pct;
    int unsigned        sink_stall_pct;
    int unsigned        cycles = 0;

    json_string_unescape_to_utf8_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > Limit) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_out(o_m_tuser, o_m_tdata, o_m_tlast);
    end

    initial begin
        int unsigned stall;
        stall = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
                stall = $urandom_range(1, 14) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function void add_byte(logic [7:0] b);
        t_src_beat t;
        t.b = b;
        t.e = 1'b0;
        src_q = {src_q, t};
    endfunction

    function void add_end();
        t_src_beat t;
        t.b = 8'($urandom);
        t.e = 1'b1;
        src_q = {src_q, t};
    endfunction

    function bit is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function void add_u(logic [15:0] v);
        add_byte(Bslash);
        add_byte(CharU);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    function logic [7:0] pick_raw();
        logic [7:0] b;
        b = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom);
        if (b == Quote || b == Bslash) b = 8'h41;
        return b;
    endfunction

    function logic [7:0] pick_escape();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = 8'h62;
            1: b = 8'h66;
            2: b = 8'h6E;
            3: b = 8'h72;
            4: b = 8'h74;
            5: b = Quote;
            6: b = Bslash;
            7: b = 8'h2F;
            default: b = 8'($urandom);
        endcase
        if (b == CharU) b = 8'h76;
        return b;
    endfunction

    function logic [15:0] pick_nonlow();
        logic [15:0] v;
        v = 16'($urandom);
        if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h4000;
        return v;
    endfunction

    function void build_string();
        logic [7:0]  b;
        int unsigned n;
        bit          closed;
        closed = 1'b0;
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0: add_byte(8'h20);
                1: add_byte(8'h09);
                2: add_byte(8'h0A);
                3: add_byte(8'h0B);
                4: add_byte(8'h0C);
                default: add_byte(8'h0D);
            endcase
        end
        case ($urandom_range(0, 19))
            0: begin
                b = 8'($urandom);
                if (b == Quote || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) b = 8'h7B;
                add_byte(b);
            end
            1: add_end();
            default: ;
        endcase
        add_byte(Quote);
        n = $urandom_range(0, 8);
        for (int k = 0; k < n && !closed; k++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: add_byte(pick_raw());
                5, 6: begin
                    add_byte(Bslash);
                    add_byte(pick_escape());
                end
                7: add_u(16'($urandom_range(0, 16'h7F)));
                8: add_u(16'($urandom_range(16'h80, 16'h7FF)));
                9: add_u(16'($urandom_range(16'h800, 16'hFFFF)));
                10, 11: begin
                    add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    add_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                12: add_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
                13: begin
                    add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    case ($urandom_range(0, 3))
                        0: begin
                            b = $urandom_range(0, 3) == 0 ? Quote : pick_raw();
                            add_byte(b);
                            closed = (b == Quote);
                        end
                        1: begin
                            add_byte(Bslash);
                            add_byte(pick_escape());
                        end
                        2: add_u(pick_nonlow());
                        default: add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    endcase
                end
                14: begin
                    add_byte(Bslash);
                    add_byte(CharU);
                    repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
                    do b = 8'($urandom); while (is_hex(b));
                    add_byte(b);
                    closed = 1'b1;
                end
                default: begin
                    b = 8'($urandom);
                    add_byte(b);
                    closed = (b == Quote);
                end
            endcase
        end
        if (!closed) begin
            case ($urandom_range(0, 9))
                0: add_end();
                1: begin
                    case ($urandom_range(0, 2))
                        0: add_byte(Bslash);
                        1: begin
                            add_byte(Bslash);
                            add_byte(CharU);
                            repeat ($urandom_range(1, 3)) add_byte(hex_char(4'($urandom)));
                        end
                        default: add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    endcase
                    add_end();
                end
                default: add_byte(Quote);
            endcase
        end
    endfunction

    task send_source();
        t_src_beat t;
        while (src_q.size() > 0) begin
            t = src_q.pop_front();
            if (!calm && src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= t.b;
            i_s_tuser  <= t.e;
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            sb.note_source(t.b, t.e);
        end
    endtask

    task drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned strings;
        sb             = new();
        calm           = 1'b0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tuser  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank skip, raw extremes, \n, surrogate pair, junk, end while waiting
        add_byte(8'h20);
        add_byte(Quote);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(Bslash);
        add_byte(8'h6E);
        add_u(16'hD83D);
        add_u(16'hDE00);
        add_byte(Quote);
        add_byte(8'h78);
        add_end();
        // bad hex digit, then an unterminated string
        add_byte(Quote);
        add_byte(Bslash);
        add_byte(CharU);
        add_byte(8'h30);
        add_byte(8'h67);
        add_byte(Quote);
        add_byte(8'h61);
        add_end();
        sink_stall_pct = 20;
        send_source();
        drain();

        sent    = 0;
        strings = 0;
        while (sent < RandItems) begin
            if (strings % 12 == 0) begin
                case ($urandom_range(0, 2))
                    0: src_gap_pct = 0;
                    1: src_gap_pct = 10;
                    default: src_gap_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_stall_pct = 0;
                    1: sink_stall_pct = 10;
                    default: sink_stall_pct = 35;
                endcase
            end
            if (sent > RandItems - 60) calm = 1'b1;
            build_string();
            sent += src_q.size();
            send_source();
            strings++;
            if (strings % 25 == 0) drain();
        end

        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
